>>> hdl/fsin_pkg.sv
package fsin_pkg;

  localparam logic [31:0] QNAN       = 32'h7fc00000;
  localparam logic [31:0] PI_F       = 32'h40490fdb;
  localparam logic [31:0] TWO_PI_F   = 32'h40c90fdb;
  localparam logic [31:0] HALF_PI_F  = 32'h3fc90fdb;
  localparam logic [31:0] QUART_PI_F = 32'h3f490fdb;
  localparam logic [31:0] ONE_F      = 32'h3f800000;
  localparam logic [31:0] HALF_F     = 32'h3f000000;
  localparam logic [31:0] S7_F       = 32'hb94d64b6;
  localparam logic [31:0] S5_F       = 32'h3c088666;
  localparam logic [31:0] S3_F       = 32'hbe2aaaac;
  localparam logic [31:0] C6_F       = 32'hbab38106;
  localparam logic [31:0] C4_F       = 32'h3d2aa789;

  // shared unit operation codes
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } fpu_ctl_t;

  // ordered compare of two non-negative finite floats: a >= b
  function automatic logic fge(input logic [31:0] a, input logic [31:0] b);
    fge = (a[30:0] >= b[30:0]);
  endfunction

endpackage

>>> hdl/fsin_fpu.sv
// Multi-cycle binary32 add/sub/mul, round to nearest even, subnormals kept.
// Finite operands only. Result valid in done cycle.
module fsin_fpu (
  input  logic               clk,
  input  logic               rst,
  input  fsin_pkg::fpu_ctl_t ctl,
  input  logic [31:0]        a,
  input  logic [31:0]        b,
  output logic [31:0]        res,
  output logic               done
);
  import fsin_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALIGN = 3'd1;
  localparam logic [2:0] S_OP    = 3'd2;
  localparam logic [2:0] S_NORM  = 3'd3;
  localparam logic [2:0] S_ROUND = 3'd4;

  logic [2:0]  state;
  logic [1:0]  op;
  logic        sa, sb, sr;
  logic [9:0]  ea, eb;
  logic [23:0] ma, mb;
  // working magnitude: value = mw * 2^(ew - 150 - 26) roughly; 50 bits
  logic [49:0] mw;
  logic signed [10:0] ew;
  logic        sticky;

  logic [7:0] a_e, b_e;
  assign a_e = a[30:23];
  assign b_e = b[30:23];

  // full 48-bit mantissa product
  logic [47:0] prod;
  assign prod = ma * mb;

  // normalization: top bit of mw; S_NORM shifts one bit at a time
  logic lz_top;
  assign lz_top = mw[49];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (ctl.start) begin
            op <= ctl.op;
            sa <= a[31];
            sb <= (ctl.op == OP_SUB) ? ~b[31] : b[31];
            ea <= {2'b0, (a_e == 8'd0) ? 8'd1 : a_e};
            eb <= {2'b0, (b_e == 8'd0) ? 8'd1 : b_e};
            ma <= {(a_e != 8'd0), a[22:0]};
            mb <= {(b_e != 8'd0), b[22:0]};
            state <= (ctl.op == OP_MUL) ? S_OP : S_ALIGN;
          end
        end
        S_ALIGN: begin
          // order so that a has the larger magnitude
          if ({ea, ma} < {eb, mb}) begin
            ea <= eb; eb <= ea; ma <= mb; mb <= ma; sa <= sb; sb <= sa;
          end
          state <= S_OP;
        end
        S_OP: begin
          sticky <= 1'b0;
          if (op == OP_MUL) begin
            // product of 24x24 with exponent; value = mw * 2^(ew-150-46+...)
            mw <= {2'b0, prod};
            sr <= sa ^ sb;
            ew <= $signed({1'b0, ea}) + $signed({1'b0, eb}) - 11'sd124;
          end else begin : addsub
            logic [9:0]  d;
            logic [49:0] bx;
            logic        st;
            d  = ea - eb;
            bx = {1'b0, mb, 25'b0};
            st = 1'b0;
            if (d > 10'd26) begin
              st = (mb != 24'd0);
              bx = 50'd0;
            end else begin
              st = |(bx & ((50'd1 << d[4:0]) - 50'd1));
              bx = bx >> d[4:0];
            end
            sr <= sa;
            if (sa == sb) mw <= {1'b0, ma, 25'b0} + bx + {49'b0, st};
            else          mw <= {1'b0, ma, 25'b0} - bx - {49'b0, st};
            ew <= $signed({1'b0, ea}) + 11'sd1;
          end
          state <= S_NORM;
        end
        S_NORM: begin
          // bring leading one to bit 49 (or stop at min exponent)
          if (mw == 50'd0) begin
            state <= S_ROUND;
          end else if (!lz_top && ew > 11'sd1) begin
            mw <= mw << 1;
            ew <= ew - 11'sd1;
          end else if (ew < 11'sd1) begin
            sticky <= sticky | mw[0];
            mw <= mw >> 1;
            ew <= ew + 11'sd1;
          end else begin
            state <= S_ROUND;
          end
        end
        default: begin
          // round: keep mw[49:26] (24 bits), guard mw[25], rest sticky
          begin : rnd
            logic [24:0] m;
            logic        g, s;
            logic [10:0] e;
            m = {1'b0, mw[49:26]};
            g = mw[25];
            s = (|mw[24:0]) | sticky;
            if (g && (s || m[0])) m = m + 25'd1;
            e = ew;
            if (m[24]) begin
              m = m >> 1;
              e = e + 11'sd1;
            end
            if (mw == 50'd0)
              res <= (op == OP_MUL) ? {sr, 31'b0} : 32'b0;
            else if (!m[23])
              res <= {sr, 8'd0, m[22:0]};
            else
              res <= {sr, e[7:0], m[22:0]};
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/float_sine_unit_core.sv
// Float sine: one item at a time; ready only while idle with no result held.
// Inf/NaN input returns QNaN without using the shared unit; else 8 to 10
// shared-unit ops, each normalizing one shift at a time, for inputs up to 2*pi.
// Larger inputs are reduced first: step doubles by exponent increment, then each
// halving may subtract (at most 256 halvings). Next item accepted the cycle
// after the result is taken. Reset (rst, synchronous): sequencer idle, no result.
module float_sine_unit_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] angle_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] sine_bits
);
  import fsin_pkg::*;

  localparam logic [4:0] Q_IDLE  = 5'd0;
  localparam logic [4:0] Q_GROW  = 5'd1;
  localparam logic [4:0] Q_RED   = 5'd2;
  localparam logic [4:0] Q_RSUB  = 5'd3;
  localparam logic [4:0] Q_HALVE = 5'd4;
  localparam logic [4:0] Q_FPI   = 5'd5;
  localparam logic [4:0] Q_FHALF = 5'd6;
  localparam logic [4:0] Q_FQ    = 5'd7;
  localparam logic [4:0] Q_T2    = 5'd8;
  localparam logic [4:0] Q_P1    = 5'd9;
  localparam logic [4:0] Q_P2    = 5'd10;
  localparam logic [4:0] Q_P3    = 5'd11;
  localparam logic [4:0] Q_P4    = 5'd12;
  localparam logic [4:0] Q_P5    = 5'd13;
  localparam logic [4:0] Q_P6    = 5'd14;
  localparam logic [4:0] Q_P7    = 5'd15;
  localparam logic [4:0] Q_OUT   = 5'd16;
  localparam logic [4:0] Q_WAIT  = 5'd17;

  logic [4:0]  state, ret;
  logic [31:0] x, step, t2;
  logic        neg, use_cos;
  logic [8:0]  guard;
  fpu_ctl_t    ctl;
  logic [31:0] fa, fb, fr;
  logic        fdone;

  fsin_fpu u_fpu (
    .clk(clk), .rst(rst), .ctl(ctl), .a(fa), .b(fb), .res(fr), .done(fdone)
  );

  assign in_ready = (state == Q_IDLE) && !out_valid;

  // issue helper: launch op then wait, returning to ret
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= Q_IDLE;
      ret       <= Q_IDLE;
      out_valid <= 1'b0;
      ctl       <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        Q_IDLE: begin
          if (in_valid && in_ready) begin
            neg   <= angle_bits[31] || (angle_bits[30:0] == 31'd0);
            x     <= {1'b0, angle_bits[30:0]};
            step  <= TWO_PI_F;
            guard <= 9'd0;
            if (angle_bits[30:23] == 8'hff) begin
              sine_bits <= QNAN;
              out_valid <= 1'b1;
            end else if (angle_bits[30:0] <= TWO_PI_F[30:0]) begin
              state <= Q_FPI;
            end else begin
              state <= Q_GROW;
            end
          end
        end
        // doubling is exact: exponent increment
        Q_GROW: begin
          if (fge(x, {step[31:23] + 9'd1, step[22:0]}))
            step <= {step[31:23] + 9'd1, step[22:0]};
          else
            state <= Q_RED;
        end
        Q_RED: begin
          if (fge(x, TWO_PI_F) && guard != 9'd256) begin
            if (fge(x, step)) begin
              fa <= x; fb <= step; ctl <= '{start: 1'b1, op: OP_SUB};
              ret <= Q_RSUB; state <= Q_WAIT;
            end else begin
              state <= Q_HALVE;
            end
          end else begin
            state <= Q_FPI;
          end
        end
        Q_RSUB: begin
          x <= fr;
          state <= Q_HALVE;
        end
        Q_HALVE: begin
          step  <= {step[31:23] - 9'd1, step[22:0]};
          guard <= guard + 9'd1;
          state <= Q_RED;
        end
        // fold at pi
        Q_FPI: begin
          if (fge(x, PI_F)) begin
            fa <= x; fb <= PI_F; ctl <= '{start: 1'b1, op: OP_SUB};
            neg <= ~neg;
            ret <= Q_FHALF; state <= Q_WAIT;
          end else begin
            state <= Q_FHALF;
          end
        end
        Q_FHALF: begin : fh
          logic [31:0] v;
          v = (ret == Q_FHALF) ? fr : x;
          if (fge(v, HALF_PI_F)) begin
            fa <= PI_F; fb <= v; ctl <= '{start: 1'b1, op: OP_SUB};
            ret <= Q_FQ; state <= Q_WAIT;
          end else begin
            x <= v;
            ret <= Q_IDLE;
            state <= Q_FQ;
          end
        end
        Q_FQ: begin : fq
          logic [31:0] v;
          v = (ret == Q_FQ) ? fr : x;
          if (!fge(v, QUART_PI_F) || v == QUART_PI_F) begin
            use_cos <= 1'b0;
            x <= v;
            fa <= v; fb <= v; ctl <= '{start: 1'b1, op: OP_MUL};
            ret <= Q_P1; state <= Q_WAIT;
          end else begin
            use_cos <= 1'b1;
            fa <= HALF_PI_F; fb <= v; ctl <= '{start: 1'b1, op: OP_SUB};
            ret <= Q_T2; state <= Q_WAIT;
          end
        end
        Q_T2: begin
          x <= fr;
          fa <= fr; fb <= fr; ctl <= '{start: 1'b1, op: OP_MUL};
          ret <= Q_P1; state <= Q_WAIT;
        end
        Q_P1: begin
          t2 <= fr;
          fa <= use_cos ? C6_F : S7_F; fb <= fr; ctl <= '{start: 1'b1, op: OP_MUL};
          ret <= Q_P2; state <= Q_WAIT;
        end
        Q_P2: begin
          fa <= fr; fb <= use_cos ? C4_F : S5_F; ctl <= '{start: 1'b1, op: OP_ADD};
          ret <= Q_P3; state <= Q_WAIT;
        end
        Q_P3: begin
          fa <= fr; fb <= t2; ctl <= '{start: 1'b1, op: OP_MUL};
          ret <= Q_P4; state <= Q_WAIT;
        end
        Q_P4: begin
          fa <= fr; fb <= use_cos ? HALF_F : S3_F;
          ctl <= '{start: 1'b1, op: (use_cos ? OP_SUB : OP_ADD)};
          ret <= Q_P5; state <= Q_WAIT;
        end
        Q_P5: begin
          fa <= fr; fb <= t2; ctl <= '{start: 1'b1, op: OP_MUL};
          ret <= Q_P6; state <= Q_WAIT;
        end
        Q_P6: begin
          fa <= fr; fb <= ONE_F; ctl <= '{start: 1'b1, op: OP_ADD};
          ret <= use_cos ? Q_OUT : Q_P7; state <= Q_WAIT;
        end
        Q_P7: begin
          fa <= fr; fb <= x; ctl <= '{start: 1'b1, op: OP_MUL};
          ret <= Q_OUT; state <= Q_WAIT;
        end
        Q_OUT: begin
          sine_bits <= {fr[31] ^ neg, fr[30:0]};
          out_valid <= 1'b1;
          state     <= Q_IDLE;
        end
        // start is a one-cycle pulse: dropped on the first wait cycle
        Q_WAIT: begin
          ctl.start <= 1'b0;
          if (fdone) state <= ret;
        end
        default: state <= Q_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != Q_IDLE) |-> !in_ready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(sine_bits)))
    else $error("result dropped");
  a_no_start_wait: assert property (@(posedge clk) disable iff (rst)
    (state == Q_WAIT && !fdone) |=> (state == Q_WAIT || state == ret))
    else $error("left wait early");
`endif

endmodule
